>>> sv/fbr_pkg.sv
// fbr_pkg: shared constants, types and codes of the framed byte receiver
// no dependencies; used by every other file of the block
`default_nettype none

package fbr_pkg;

  // buffer geometry (depth is a power of two)
  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam logic [ADDR_W:0] LAST_IDX = (ADDR_W+1)'(BUFFER_DEPTH - 1);

  // field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int RIDX_W = 8;
  localparam int CNT_W  = 9;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_RX_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // framing bytes
  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h43;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h47;
  localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h53;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h57;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_FRAMED_MODE = 1'b0;

  // decoded operation
  typedef enum logic [1:0] {
    OP_NOP,
    OP_BYTE,
    OP_READ,
    OP_CLEAR
  } op_t;

  // framing class of the received byte
  typedef struct packed {
    logic hdr1;
    logic hdr2;
    logic trl1;
    logic trl2;
  } byte_class_t;

  // one classified item in the queue
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
    byte_class_t       cls;
    logic [ADDR_W-1:0] read_addr;
  } q_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> sv/fbr_in_if.sv
// fbr_in_if: input item channel (valid/ready with command payload)
// depends on fbr_pkg for field widths
`default_nettype none

interface fbr_in_if;
  logic                       valid;
  logic                       ready;
  logic [fbr_pkg::CMD_W-1:0]  command;
  logic [fbr_pkg::BYTE_W-1:0] rx_byte;
  logic [fbr_pkg::RIDX_W-1:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

`default_nettype wire

>>> sv/fbr_out_if.sv
// fbr_out_if: result item channel (valid/ready with status payload)
// depends on fbr_pkg for field widths
`default_nettype none

interface fbr_out_if;
  logic                       valid;
  logic                       ready;
  logic [fbr_pkg::BYTE_W-1:0] read_data;
  logic                       frame_done;
  logic [fbr_pkg::CNT_W-1:0]  byte_count;
  logic                       receiving;

  modport source (output valid, read_data, frame_done, byte_count, receiving, input ready);
  modport sink   (input valid, read_data, frame_done, byte_count, receiving, output ready);
endinterface

`default_nettype wire

>>> sv/fbr_front.sv
// fbr_front: accepts input items, decodes the command and classifies the byte
// depends on fbr_pkg and fbr_in_if; feeds fbr_queue
`default_nettype none

module fbr_front (
  fbr_in_if.sink              in_ch,
  input  fbr_pkg::q_stat_t    stat,
  output logic                push,
  output fbr_pkg::q_entry_t   push_data
);
  import fbr_pkg::*;

  logic [RIDX_W+ADDR_W-1:0] ridx_ext;

  // take an item whenever the queue has room
  assign in_ch.ready = !stat.full;
  assign push        = in_ch.valid && !stat.full;

  // read index wraps on the buffer depth
  assign ridx_ext = {{ADDR_W{1'b0}}, in_ch.read_index};

  // command decode and byte classification
  always_comb begin
    push_data           = '0;
    push_data.rx_byte   = in_ch.rx_byte;
    push_data.read_addr = ridx_ext[ADDR_W-1:0];
    push_data.cls.hdr1  = (in_ch.rx_byte == HDR_FIRST);
    push_data.cls.hdr2  = (in_ch.rx_byte == HDR_SECOND);
    push_data.cls.trl1  = (in_ch.rx_byte == TRL_FIRST);
    push_data.cls.trl2  = (in_ch.rx_byte == TRL_SECOND);
    unique case (in_ch.command)
      CMD_RX_BYTE: push_data.op = OP_BYTE;
      CMD_READ:    push_data.op = OP_READ;
      CMD_CLEAR:   push_data.op = OP_CLEAR;
      default:     push_data.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/fbr_queue.sv
// fbr_queue: small fifo of classified items between front and back
// depends on fbr_pkg
`default_nettype none

module fbr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbr_pkg::q_entry_t   push_data,
  input  logic                pop,
  output fbr_pkg::q_entry_t   head,
  output fbr_pkg::q_stat_t    stat
);
  import fbr_pkg::*;

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head           = slot_r[rd_ptr_r];
  assign stat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.not_empty = (count_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/fbr_back.sv
// fbr_back: executes queued items on the frame buffer and framing state,
// holds the result register; depends on fbr_pkg and fbr_out_if
`default_nettype none

module fbr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                framed_mode,
  input  fbr_pkg::q_entry_t   head,
  input  fbr_pkg::q_stat_t    stat,
  output logic                pop,
  fbr_out_if.source           out_ch
);
  import fbr_pkg::*;

  // framing state
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic              done_r, done_nxt;
  logic              hdr_r, hdr_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              trl_r, trl_nxt;

  // buffer: entry 0 in its own register so a header can write two entries
  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] valid_r;
  logic [BYTE_W-1:0] entry0_r;
  logic              entry0_valid_r;

  // write controls
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              hdr_wr;
  logic [ADDR_W:0]   raw_inc;

  // result register
  logic              out_valid_r;
  logic              is_rd_r;
  logic              sel0_r;
  logic              hit_r;
  logic              hit0_r;
  logic [BYTE_W-1:0] mem_q_r;
  logic [BYTE_W-1:0] e0_q_r;
  logic [CNT_W+ADDR_W-1:0] cnt_ext;

  logic              slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = stat.not_empty && slot_free;

  // next framing state and buffer write for the head item
  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    done_nxt     = done_r;
    hdr_nxt      = hdr_r;
    in_frame_nxt = in_frame_r;
    trl_nxt      = trl_r;
    wr_en        = 1'b0;
    wr_addr      = wr_idx_r;
    hdr_wr       = 1'b0;
    raw_inc      = {1'b0, wr_idx_r} + (ADDR_W+1)'(1);
    case (head.op)
      OP_BYTE: begin
        if (!done_r && !framed_mode) begin
          // raw store with wrap
          wr_en      = 1'b1;
          wr_idx_nxt = (raw_inc > LAST_IDX) ? '0 : raw_inc[ADDR_W-1:0];
        end else if (!done_r) begin
          // header detection
          if (!hdr_r && head.cls.hdr1) begin
            hdr_nxt = 1'b1;
          end else if (hdr_r && head.cls.hdr2) begin
            hdr_wr       = 1'b1;
            wr_idx_nxt   = ADDR_W'(1);
            in_frame_nxt = 1'b1;
          end else begin
            hdr_nxt = 1'b0;
          end
          if (in_frame_nxt) begin
            // overflow aborts the frame and restarts at entry 0
            if ({1'b0, wr_idx_nxt} >= LAST_IDX) begin
              trl_nxt      = 1'b0;
              in_frame_nxt = 1'b0;
              wr_idx_nxt   = '0;
            end
            wr_en      = 1'b1;
            wr_addr    = wr_idx_nxt;
            wr_idx_nxt = wr_idx_nxt + ADDR_W'(1);
            // trailer detection
            if (!trl_nxt && head.cls.trl1) begin
              trl_nxt = 1'b1;
            end else if (trl_nxt && head.cls.trl2) begin
              wr_idx_nxt   = '0;
              done_nxt     = 1'b1;
              in_frame_nxt = 1'b0;
              trl_nxt      = 1'b0;
            end else begin
              trl_nxt = 1'b0;
            end
          end
        end
      end
      OP_CLEAR: begin
        wr_idx_nxt = '0;
        done_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control state, valid bits and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r       <= '0;
      done_r         <= 1'b0;
      hdr_r          <= 1'b0;
      in_frame_r     <= 1'b0;
      trl_r          <= 1'b0;
      valid_r        <= '0;
      entry0_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (pop) begin
        wr_idx_r   <= wr_idx_nxt;
        done_r     <= done_nxt;
        hdr_r      <= hdr_nxt;
        in_frame_r <= in_frame_nxt;
        trl_r      <= trl_nxt;
        if (hdr_wr || (wr_en && wr_addr == '0)) begin
          entry0_valid_r <= 1'b1;
        end
        if (wr_en && wr_addr != '0) begin
          valid_r[wr_addr] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // buffer writes
  always_ff @(posedge clk) begin
    if (pop && hdr_wr) begin
      entry0_r <= HDR_FIRST;
    end else if (pop && wr_en && wr_addr == '0) begin
      entry0_r <= head.rx_byte;
    end
    if (pop && wr_en && wr_addr != '0) begin
      mem[wr_addr] <= head.rx_byte;
    end
  end

  // buffer read, registered with the result
  always_ff @(posedge clk) begin
    if (pop) begin
      is_rd_r <= (head.op == OP_READ);
      sel0_r  <= (head.read_addr == '0);
      mem_q_r <= mem[head.read_addr];
      hit_r   <= valid_r[head.read_addr];
      e0_q_r  <= entry0_r;
      hit0_r  <= entry0_valid_r;
    end
  end

  // status fields follow the state, which only moves when a result is loaded
  assign cnt_ext           = {{CNT_W{1'b0}}, wr_idx_r};
  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_done = done_r;
  assign out_ch.byte_count = cnt_ext[CNT_W-1:0];
  assign out_ch.receiving  = in_frame_r;
  assign out_ch.read_data  = !is_rd_r ? '0 :
                             sel0_r   ? (hit0_r ? e0_q_r : '0) :
                                        (hit_r ? mem_q_r : '0);

  // a finished frame cannot still be receiving
  a_done_not_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && in_frame_r))
    else $error("frame done while still inside a frame");

  // clear zeroes count and done
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.op == OP_CLEAR) |=> (wr_idx_r == '0 && !done_r))
    else $error("clear item left count or done set");

  // done holds until a clear item
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !(pop && head.op == OP_CLEAR)) |=> done_r)
    else $error("done dropped without a clear item");

  // a frame starts with header bytes at entries 0 and 1
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_frame_r) |-> (wr_idx_r == ADDR_W'(2)))
    else $error("frame start left a wrong write index");

endmodule

`default_nettype wire

>>> sv/framed_byte_receiver_core.sv
// framed_byte_receiver_core: the accepting edge writes the item queue; the result register is
// loaded when the item leaves the queue, which waits while an untaken result is held, and the
// result can be taken from then on. throughput one item per cycle while results are taken.
// synchronous active-low reset clears mode, framing state and buffer valid bits;
// buffer entries never written read as zero.
// depends on fbr_pkg, fbr_in_if, fbr_out_if, fbr_front, fbr_queue, fbr_back
`default_nettype none

module framed_byte_receiver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  fbr_in_if.sink                         in_ch,
  fbr_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbr_pkg::PADDR_W-1:0]    paddr,
  input  logic [fbr_pkg::PDATA_W-1:0]    pwdata,
  output logic [fbr_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import fbr_pkg::*;

  logic       framed_mode_r;
  logic       cfg_wr;
  logic       push;
  logic       pop;
  q_entry_t   push_data;
  q_entry_t   head;
  q_stat_t    stat;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[PADDR_W-1:2] == REG_FRAMED_MODE);
  assign prdata = (paddr[PADDR_W-1:2] == REG_FRAMED_MODE) ?
                  {{(PDATA_W-1){1'b0}}, framed_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framed_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      framed_mode_r <= pwdata[0];
    end
  end

  // front: accept and classify
  fbr_front u_front (
    .in_ch     (in_ch),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // item queue
  fbr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // back: execute and deliver results
  fbr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .framed_mode (framed_mode_r),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
